FILE: design/mtpc_pkg.sv
// Shared constants, command codes and result packing for the memory test pattern checker.
`default_nettype none

package mtpc_pkg;

    localparam int DATA_W  = 32;
    localparam int STEP_W  = 8;
    localparam int CMD_W   = 2;
    localparam int WIDTH_W = 2;
    localparam int CFG_IDX_W = 2;

    // Commands carried in the input beat's tuser.
    localparam logic [CMD_W-1:0] CMD_START_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START_CHECK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK_STEP  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_ADDRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCESS_WIDTH  = 2'd2;

    // Access width codes; the unused code behaves as a word access.
    localparam logic [WIDTH_W-1:0] WIDTH_BYTE = 2'd0;
    localparam logic [WIDTH_W-1:0] WIDTH_HALF = 2'd1;

    localparam logic [DATA_W-1:0] START_ADDRESS_RST = 32'h0000_2000;
    localparam logic [DATA_W-1:0] END_ADDRESS_RST   = 32'h0000_4000;
    localparam logic [DATA_W-1:0] SEED_ALL          = 32'h4433_2211;
    localparam logic [DATA_W-1:0] COUNT_MAX         = 32'hFFFF_FFFF;

    localparam int RES_PAD_W = 6;

    // Result beat payload; the last member sits in the lowest bits.
    typedef struct packed {
        logic [RES_PAD_W-1:0] pad;
        logic [DATA_W-1:0]    first_error_data;
        logic [DATA_W-1:0]    first_error_address;
        logic [DATA_W-1:0]    error_count;
        logic                 pass_done;
        logic                 mismatch;
        logic [DATA_W-1:0]    pattern_data;
        logic [DATA_W-1:0]    address;
    } result_t;

    localparam int RES_W = $bits(result_t);

    function automatic logic [DATA_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [DATA_W-1:0] m;
        case (w)
            WIDTH_BYTE: m = 32'h0000_00FF;
            WIDTH_HALF: m = 32'h0000_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] width_bytes(input logic [WIDTH_W-1:0] w);
        logic [2:0] b;
        case (w)
            WIDTH_BYTE: b = 3'd1;
            WIDTH_HALF: b = 3'd2;
            default:    b = 3'd4;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: design/memory_test_pattern_checker_top.sv
// Memory write/read/verify self-test engine with a skid-buffered result stream.
// A result beat is registered in the output register, or in the skid register during a result stall.
// Throughput: one input beat per cycle while the skid register is empty.
// A result register and a skid register take one more input beat during a result stall.
// Reset (aresetn low, synchronous) restores the configuration defaults and the seed
// pattern, and clears the error capture and both output entries.
`default_nettype none

module memory_test_pattern_checker_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [mtpc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [mtpc_pkg::DATA_W-1:0]       cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mtpc_pkg::DATA_W-1:0]       s_tdata,  // read_data
    input  wire logic [mtpc_pkg::CMD_W-1:0]        s_tuser,  // cmd
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // address, pattern_data, mismatch, pass_done, error_count,
    // first_error_address, first_error_data, zero fill
    output logic [mtpc_pkg::RES_W-1:0]             m_tdata,
    output logic                                   m_tuser   // valid_res
);

    // Configuration registers
    logic [mtpc_pkg::DATA_W-1:0]  start_address_reg;
    logic [mtpc_pkg::DATA_W-1:0]  end_address_reg;
    logic [mtpc_pkg::WIDTH_W-1:0] access_width_reg;

    // Test state
    logic [mtpc_pkg::DATA_W-1:0] position_reg, position_next;
    logic [mtpc_pkg::DATA_W-1:0] pattern_reg, pattern_next;
    logic [mtpc_pkg::STEP_W-1:0] step_reg, step_next;
    logic [mtpc_pkg::DATA_W-1:0] total_reg, total_next;
    logic [mtpc_pkg::DATA_W-1:0] fail_addr_reg, fail_addr_next;
    logic [mtpc_pkg::DATA_W-1:0] fail_data_reg, fail_data_next;

    // Output entries
    logic                    out_valid_reg, skid_valid_reg;
    mtpc_pkg::result_t       out_data_reg, skid_data_reg;
    logic                    out_user_reg, skid_user_reg;

    logic                        accept;
    logic [mtpc_pkg::DATA_W-1:0] mask;
    logic [mtpc_pkg::DATA_W:0]   pos_sum;
    logic [mtpc_pkg::DATA_W-1:0] pos_adv;
    logic [mtpc_pkg::STEP_W-1:0] step_inc;
    logic [mtpc_pkg::DATA_W-1:0] rd_masked;
    logic                        in_region;
    logic                        is_start;
    logic                        miss;
    mtpc_pkg::result_t           res;
    logic                        res_valid;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        mask      = mtpc_pkg::width_mask(access_width_reg);
        pos_sum   = {1'b0, position_reg} + {{(mtpc_pkg::DATA_W-2){1'b0}},
                                            mtpc_pkg::width_bytes(access_width_reg)};
        pos_adv   = pos_sum[mtpc_pkg::DATA_W] ? mtpc_pkg::COUNT_MAX
                                              : pos_sum[mtpc_pkg::DATA_W-1:0];
        step_inc  = step_reg + 8'd1;
        rd_masked = s_tdata & mask;
        in_region = position_reg < end_address_reg;
        is_start  = (s_tuser == mtpc_pkg::CMD_START_WRITE)
                 || (s_tuser == mtpc_pkg::CMD_START_CHECK);

        position_next  = position_reg;
        pattern_next   = pattern_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        fail_addr_next = fail_addr_reg;
        fail_data_next = fail_data_reg;
        miss           = 1'b0;
        res_valid      = 1'b0;
        res.address      = position_reg;
        res.pattern_data = pattern_reg & mask;

        if (is_start) begin
            if (s_tuser == mtpc_pkg::CMD_START_WRITE) begin
                total_next     = '0;
                fail_addr_next = '0;
                fail_data_next = '0;
            end
            position_next    = start_address_reg;
            pattern_next     = mtpc_pkg::SEED_ALL & mask;
            step_next        = '0;
            res.address      = start_address_reg;
            res.pattern_data = mtpc_pkg::SEED_ALL & mask;
        end else if (in_region) begin
            res_valid = 1'b1;
            if (s_tuser == mtpc_pkg::CMD_CHECK_STEP && rd_masked != (pattern_reg & mask)) begin
                miss = 1'b1;
                if (total_reg == '0) begin
                    fail_addr_next = position_reg;
                    fail_data_next = rd_masked;
                end
                if (total_reg != mtpc_pkg::COUNT_MAX) begin
                    total_next = total_reg + 32'd1;
                end
            end
            position_next = pos_adv;
            step_next     = step_inc;
            pattern_next  = pattern_reg ^ {4{step_inc}};
        end

        res.pad                 = '0;
        res.mismatch            = miss;
        res.pass_done           = position_next >= end_address_reg;
        res.error_count         = total_next;
        res.first_error_address = fail_addr_next;
        res.first_error_data    = fail_data_next;
    end

    // Configuration and test state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_address_reg <= mtpc_pkg::START_ADDRESS_RST;
            end_address_reg   <= mtpc_pkg::END_ADDRESS_RST;
            access_width_reg  <= mtpc_pkg::WIDTH_BYTE;
            position_reg      <= mtpc_pkg::START_ADDRESS_RST;
            pattern_reg       <= mtpc_pkg::SEED_ALL & mtpc_pkg::width_mask(mtpc_pkg::WIDTH_BYTE);
            step_reg          <= '0;
            total_reg         <= '0;
            fail_addr_reg     <= '0;
            fail_data_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    mtpc_pkg::REG_START_ADDRESS: start_address_reg <= cfg_data;
                    mtpc_pkg::REG_END_ADDRESS:   end_address_reg   <= cfg_data;
                    mtpc_pkg::REG_ACCESS_WIDTH:
                        access_width_reg <= cfg_data[mtpc_pkg::WIDTH_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                position_reg  <= position_next;
                pattern_reg   <= pattern_next;
                step_reg      <= step_next;
                total_reg     <= total_next;
                fail_addr_reg <= fail_addr_next;
                fail_data_reg <= fail_data_next;
            end
        end
    end

    // Output entry control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output entry payload
    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end else if (accept) begin
                out_data_reg <= res;
                out_user_reg <= res_valid;
            end
        end else if (accept) begin
            skid_data_reg <= res;
            skid_user_reg <= res_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

FILE: design/mtpc_checker.sv
// Port-level assertions for the memory test pattern checker, bound to the top level.
`default_nettype none

module mtpc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mtpc_pkg::RES_W-1:0]    m_tdata,
    input wire logic                          m_tuser
);

    mtpc_pkg::result_t res;
    assign res = m_tdata;

    // A held result beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output not empty after reset");

    // Input back-pressure only happens when a result is already waiting.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_miss_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.mismatch |-> m_tuser)
        else $error("mismatch reported without an access");

    a_miss_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.mismatch |-> res.error_count != '0)
        else $error("mismatch reported with zero error count");

endmodule

bind memory_test_pattern_checker_top mtpc_checker u_mtpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/pattern_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the memory test pattern checker: predicts every result beat and compares it.
module pattern_result_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mtpc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [mtpc_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [mtpc_pkg::DATA_W-1:0]    s_tdata,
    input  wire logic [mtpc_pkg::CMD_W-1:0]     s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [mtpc_pkg::RES_W-1:0]     m_tdata,
    input  wire logic                           m_tuser,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  checked_count,
    output int                                  flagged_count
);

    typedef struct packed {
        logic              valid_res;
        mtpc_pkg::result_t res;
    } access_outcome_t;

    access_outcome_t expected_beats[$];

    // Copy of the register file, tracked from the write port.
    logic [mtpc_pkg::DATA_W-1:0]  reg_start;
    logic [mtpc_pkg::DATA_W-1:0]  reg_end;
    logic [mtpc_pkg::WIDTH_W-1:0] reg_width;

    // Walk state of the current pass and the error capture.
    logic [mtpc_pkg::DATA_W-1:0]  walk_addr;
    logic [mtpc_pkg::DATA_W-1:0]  walk_pattern;
    logic [mtpc_pkg::STEP_W-1:0]  walk_step;
    logic [mtpc_pkg::DATA_W-1:0]  miss_total;
    logic [mtpc_pkg::DATA_W-1:0]  first_addr;
    logic [mtpc_pkg::DATA_W-1:0]  first_data;

    int                errors = 0;
    int                checked = 0;
    int                flagged = 0;
    mtpc_pkg::result_t got_beat;
    access_outcome_t   want_beat;

    function automatic logic [mtpc_pkg::DATA_W-1:0] lane_mask(
        input logic [mtpc_pkg::WIDTH_W-1:0] w);
        logic [mtpc_pkg::DATA_W-1:0] m;
        case (w)
            mtpc_pkg::WIDTH_BYTE: m = 32'h0000_00FF;
            mtpc_pkg::WIDTH_HALF: m = 32'h0000_FFFF;
            default:              m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    task automatic predict_access(input logic [mtpc_pkg::CMD_W-1:0] op,
                                  input logic [mtpc_pkg::DATA_W-1:0] rd);
        logic [mtpc_pkg::DATA_W-1:0] mask;
        logic [mtpc_pkg::DATA_W:0]   next_addr;
        logic [mtpc_pkg::DATA_W:0]   stride;
        access_outcome_t             o;
        mask = lane_mask(reg_width);
        o = '0;
        o.res.address = walk_addr;
        o.res.pattern_data = walk_pattern & mask;
        if (op == mtpc_pkg::CMD_START_WRITE || op == mtpc_pkg::CMD_START_CHECK) begin
            if (op == mtpc_pkg::CMD_START_WRITE) begin
                miss_total = '0;
                first_addr = '0;
                first_data = '0;
            end
            walk_addr = reg_start;
            walk_pattern = mtpc_pkg::SEED_ALL & mask;
            walk_step = '0;
            o.res.address = walk_addr;
            o.res.pattern_data = walk_pattern;
        end else if (walk_addr < reg_end) begin
            o.valid_res = 1'b1;
            if (op == mtpc_pkg::CMD_CHECK_STEP && (rd & mask) != (walk_pattern & mask)) begin
                o.res.mismatch = 1'b1;
                if (miss_total == '0) begin
                    first_addr = walk_addr;
                    first_data = rd & mask;
                end
                if (miss_total != mtpc_pkg::COUNT_MAX) miss_total = miss_total + 1'b1;
            end
            case (reg_width)
                mtpc_pkg::WIDTH_BYTE: stride = 33'd1;
                mtpc_pkg::WIDTH_HALF: stride = 33'd2;
                default:              stride = 33'd4;
            endcase
            // The walk sticks at the top of the address space instead of wrapping.
            next_addr = {1'b0, walk_addr} + stride;
            walk_addr = next_addr[mtpc_pkg::DATA_W] ? '1 : next_addr[mtpc_pkg::DATA_W-1:0];
            walk_step = walk_step + 1'b1;
            walk_pattern = walk_pattern ^ {4{walk_step}};
        end
        o.res.pass_done = (walk_addr >= reg_end);
        o.res.error_count = miss_total;
        o.res.first_error_address = first_addr;
        o.res.first_error_data = first_data;
        expected_beats.push_back(o);
    endtask

    task automatic compare_field(input string name, input logic [mtpc_pkg::DATA_W-1:0] want,
                                 input logic [mtpc_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reg_start = mtpc_pkg::START_ADDRESS_RST;
            reg_end = mtpc_pkg::END_ADDRESS_RST;
            reg_width = mtpc_pkg::WIDTH_BYTE;
            walk_addr = mtpc_pkg::START_ADDRESS_RST;
            walk_pattern = mtpc_pkg::SEED_ALL & lane_mask(mtpc_pkg::WIDTH_BYTE);
            walk_step = '0;
            miss_total = '0;
            first_addr = '0;
            first_data = '0;
            expected_beats.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    mtpc_pkg::REG_START_ADDRESS: reg_start = cfg_data;
                    mtpc_pkg::REG_END_ADDRESS:   reg_end = cfg_data;
                    mtpc_pkg::REG_ACCESS_WIDTH:  reg_width = cfg_data[mtpc_pkg::WIDTH_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_access(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got_beat = m_tdata;
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with none outstanding, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want_beat = expected_beats.pop_front();
                    compare_field("valid_res", 32'(want_beat.valid_res), 32'(m_tuser));
                    compare_field("address", want_beat.res.address, got_beat.address);
                    compare_field("pattern_data", want_beat.res.pattern_data,
                                  got_beat.pattern_data);
                    compare_field("mismatch", 32'(want_beat.res.mismatch),
                                  32'(got_beat.mismatch));
                    compare_field("pass_done", 32'(want_beat.res.pass_done),
                                  32'(got_beat.pass_done));
                    compare_field("error_count", want_beat.res.error_count,
                                  got_beat.error_count);
                    compare_field("first_error_address", want_beat.res.first_error_address,
                                  got_beat.first_error_address);
                    compare_field("first_error_data", want_beat.res.first_error_data,
                                  got_beat.first_error_data);
                    compare_field("zero fill", '0, 32'(got_beat.pad));
                    checked++;
                    if (want_beat.res.mismatch) flagged++;
                end
            end
        end
        pending_count <= expected_beats.size();
        fail_count <= errors;
        checked_count <= checked;
        flagged_count <= flagged;
    end

endmodule

FILE: tb/tb_memory_test_pattern_checker_top.sv
`timescale 1ns / 1ps
// Testbench top for the memory test pattern checker: clock, reset, register setup, beats, verdict.
module tb_memory_test_pattern_checker_top;

    localparam int TOTAL_ITEMS = 1550;
    localparam int CALM_ITEMS  = 200;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [mtpc_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam logic [mtpc_pkg::WIDTH_W-1:0]   WIDTH_WORD  = 2'd2;
    localparam logic [mtpc_pkg::WIDTH_W-1:0]   WIDTH_SPARE = 2'd3;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [mtpc_pkg::CFG_IDX_W-1:0] cfg_addr;
    logic [mtpc_pkg::DATA_W-1:0]    cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [mtpc_pkg::DATA_W-1:0]    s_tdata;
    logic [mtpc_pkg::CMD_W-1:0]     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [mtpc_pkg::RES_W-1:0]     m_tdata;
    logic                           m_tuser;

    int fail_count;
    int pending;
    int checked;
    int flagged;

    int   items_sent = 0;
    int   settings = 0;
    int   quiet_cycles = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic holding = 1'b0;

    // Current register values, used to shape the stimulus.
    logic [mtpc_pkg::DATA_W-1:0]  cur_start;
    logic [mtpc_pkg::DATA_W-1:0]  cur_end;
    logic [mtpc_pkg::DATA_W-1:0]  cur_mask;
    int                           cur_bytes;
    logic [3:0]                   widths_used = '0;

    // Commands whose results are still on the way, and the data the last write pass wrote.
    logic [mtpc_pkg::CMD_W-1:0]   ops_in_flight[$];
    logic [mtpc_pkg::DATA_W-1:0]  write_image[$];

    // Main sequence variables.
    logic [mtpc_pkg::WIDTH_W-1:0] pick_width;
    logic [mtpc_pkg::DATA_W-1:0]  pick_start;
    logic [mtpc_pkg::DATA_W-1:0]  pick_end;
    logic [mtpc_pkg::DATA_W-1:0]  align;
    logic [mtpc_pkg::CMD_W-1:0]   junk_op;
    longint                       region_steps;
    int                           writes;
    int                           checks;

    always #5 aclk = ~aclk;

    memory_test_pattern_checker_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pattern_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending),
        .checked_count (checked),
        .flagged_count (flagged)
    );

    // Memory image: the data of each write access, in order, so a check pass can read it back.
    always @(posedge aclk) begin
        mtpc_pkg::result_t          beat;
        logic [mtpc_pkg::CMD_W-1:0] op;
        if (aresetn && m_tvalid && m_tready && ops_in_flight.size() > 0) begin
            beat = m_tdata;
            op = ops_in_flight.pop_front();
            if (op == mtpc_pkg::CMD_START_WRITE) write_image.delete();
            else if (op == mtpc_pkg::CMD_WRITE_STEP && m_tuser)
                write_image.push_back(beat.pattern_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[memory_test_pattern_checker_top] ERROR");
            $finish;
        end
    end

    // Result side: random ready bursts, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holding = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holding = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    task automatic send_beat(input logic [mtpc_pkg::CMD_W-1:0] op,
                             input logic [mtpc_pkg::DATA_W-1:0] data);
        if (!calm && !holding && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        ops_in_flight.push_back(op);
        items_sent++;
        calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
    endtask

    // Stop offering beats and wait until every result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mtpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mtpc_pkg::DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge aclk);
    endtask

    // Only the low bits select the width; the rest are noise.
    task automatic apply_width(input logic [mtpc_pkg::WIDTH_W-1:0] w);
        write_reg(mtpc_pkg::REG_ACCESS_WIDTH, ($urandom & ~32'd3) | 32'(w));
        widths_used[w] = 1'b1;
        case (w)
            mtpc_pkg::WIDTH_BYTE: begin
                cur_mask = 32'h0000_00FF;
                cur_bytes = 1;
            end
            mtpc_pkg::WIDTH_HALF: begin
                cur_mask = 32'h0000_FFFF;
                cur_bytes = 2;
            end
            default: begin
                cur_mask = 32'hFFFF_FFFF;
                cur_bytes = 4;
            end
        endcase
    endtask

    task automatic set_region(input logic [mtpc_pkg::DATA_W-1:0] first,
                              input logic [mtpc_pkg::DATA_W-1:0] stop,
                              input logic [mtpc_pkg::WIDTH_W-1:0] w);
        drain();
        write_reg(mtpc_pkg::REG_START_ADDRESS, first);
        write_reg(mtpc_pkg::REG_END_ADDRESS, stop);
        apply_width(w);
        cfg_we <= 1'b0;
        cur_start = first;
        cur_end = stop;
        settings++;
    endtask

    // Read data for check access idx: the written value (random past the end of the image) with noise
    // above the access width, and now and then one flipped bit anywhere in the word.
    function automatic logic [mtpc_pkg::DATA_W-1:0] read_back(input int idx);
        logic [mtpc_pkg::DATA_W-1:0] d;
        d = (idx < write_image.size()) ? write_image[idx] : $urandom;
        d = (d & cur_mask) | ($urandom & ~cur_mask);
        if ($urandom_range(0, 7) == 0) d = d ^ (32'd1 << $urandom_range(0, 31));
        return d;
    endfunction

    task automatic check_pass(input int count);
        logic [mtpc_pkg::CMD_W-1:0] op;
        send_beat(mtpc_pkg::CMD_START_CHECK, $urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 29) == 0) begin
                op = mtpc_pkg::CMD_W'($urandom_range(0, 3));
                send_beat(op, $urandom);
            end else begin
                send_beat(mtpc_pkg::CMD_CHECK_STEP, read_back(i));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = mtpc_pkg::CMD_START_WRITE;
        cur_start = mtpc_pkg::START_ADDRESS_RST;
        cur_end = mtpc_pkg::END_ADDRESS_RST;
        cur_mask = 32'h0000_00FF;
        cur_bytes = 1;
        widths_used[mtpc_pkg::WIDTH_BYTE] = 1'b1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // A step straight after reset walks from the default region with the byte seed.
        send_beat(mtpc_pkg::CMD_WRITE_STEP, 32'h0000_0000);
        send_beat(mtpc_pkg::CMD_START_WRITE, 32'hFFFF_FFFF);
        send_beat(mtpc_pkg::CMD_WRITE_STEP, 32'hFFFF_FFFF);
        send_beat(mtpc_pkg::CMD_WRITE_STEP, $urandom);
        // Width changes in the middle of a pass: new stride and mask, no reseed.
        drain();
        apply_width(mtpc_pkg::WIDTH_HALF);
        cfg_we <= 1'b0;
        send_beat(mtpc_pkg::CMD_WRITE_STEP, $urandom);
        send_beat(mtpc_pkg::CMD_WRITE_STEP, $urandom);
        drain();
        apply_width(WIDTH_SPARE);
        write_reg(REG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        send_beat(mtpc_pkg::CMD_WRITE_STEP, $urandom);
        drain();
        check_pass(4);
        send_beat(mtpc_pkg::CMD_CHECK_STEP, 32'h0000_0000);
        send_beat(mtpc_pkg::CMD_CHECK_STEP, 32'hFFFF_FFFF);
        // Region at the top of the address space: the walk saturates and steps run past the end.
        set_region(32'hFFFF_FFF8, 32'hFFFF_FFFF, WIDTH_WORD);
        send_beat(mtpc_pkg::CMD_START_WRITE, $urandom);
        repeat (3) send_beat(mtpc_pkg::CMD_WRITE_STEP, $urandom);
        drain();
        check_pass(3);
        // Empty region.
        set_region(32'h0000_0000, 32'h0000_0000, mtpc_pkg::WIDTH_BYTE);
        send_beat(mtpc_pkg::CMD_START_WRITE, $urandom);
        send_beat(mtpc_pkg::CMD_WRITE_STEP, $urandom);
        send_beat(mtpc_pkg::CMD_CHECK_STEP, $urandom);

        // Long result stall while beats keep coming, so the input side backs up.
        set_region(32'h0000_1000, 32'h0000_1040, mtpc_pkg::WIDTH_HALF);
        send_beat(mtpc_pkg::CMD_START_WRITE, $urandom);
        s_tvalid <= 1'b0;
        hold_req = 1'b1;
        @(posedge aclk);
        while (!holding) @(posedge aclk);
        repeat (16) send_beat(mtpc_pkg::CMD_WRITE_STEP, $urandom);

        while (items_sent < TOTAL_ITEMS) begin
            pick_width = mtpc_pkg::WIDTH_W'($urandom_range(0, 3));
            case (pick_width)
                mtpc_pkg::WIDTH_BYTE: align = 32'hFFFF_FFFF;
                mtpc_pkg::WIDTH_HALF: align = 32'hFFFF_FFFE;
                default:              align = 32'hFFFF_FFFC;
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2: begin
                    pick_start = $urandom & align;
                    pick_end = pick_start + $urandom_range(0, 24) * (~align + 1);
                end
                3: begin
                    pick_start = $urandom;
                    pick_end = pick_start + $urandom_range(0, 40);
                end
                4: begin
                    pick_start = (32'hFFFF_FFFF - $urandom_range(0, 40)) & align;
                    pick_end = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                    : pick_start + $urandom_range(0, 20);
                end
                5: begin
                    pick_start = 32'h0000_0000;
                    pick_end = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                          : $urandom_range(0, 40);
                end
                6: begin
                    pick_start = $urandom;
                    pick_end = $urandom;
                end
                default: begin
                    pick_start = $urandom & align;
                    pick_end = pick_start - $urandom_range(0, 8);
                end
            endcase
            set_region(pick_start, pick_end, pick_width);
            repeat ($urandom_range(1, 4)) begin
                if (cur_end <= cur_start) region_steps = 0;
                else region_steps = (longint'(cur_end) - longint'(cur_start) + cur_bytes - 1)
                                    / cur_bytes;
                if (region_steps > 30) writes = $urandom_range(1, 20);
                else if ($urandom_range(0, 5) == 0) writes = $urandom_range(0, int'(region_steps));
                else writes = int'(region_steps) + $urandom_range(0, 2);
                checks = ($urandom_range(0, 5) == 0) ? $urandom_range(0, writes)
                                                      : writes + $urandom_range(0, 1);
                send_beat(mtpc_pkg::CMD_START_WRITE, $urandom);
                repeat (writes) send_beat(mtpc_pkg::CMD_WRITE_STEP, $urandom);
                drain();
                check_pass(checks);
                // A second check pass keeps the error count and capture of the first.
                if ($urandom_range(0, 3) == 0) begin
                    drain();
                    check_pass(checks);
                end
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        junk_op = mtpc_pkg::CMD_W'($urandom_range(0, 3));
                        send_beat(junk_op, $urandom);
                    end
                end
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Run covered %0d input beats over %0d register settings, access width codes %b.",
                 items_sent, settings, widths_used);
        $display("%0d result beats compared, %0d of them check accesses with a data mismatch.",
                 checked, flagged);
        if (fail_count == 0) begin
            $display("[memory_test_pattern_checker_top] OK");
        end else begin
            $display("[memory_test_pattern_checker_top] ERROR");
        end
        $finish;
    end

endmodule
